// ===== sv/radar_range_gate_tracker_unit_macros.svh =====
// assertion macros for the range gate tracker checker
// used by rrgt_checker only
`ifndef RADAR_RANGE_GATE_TRACKER_UNIT_MACROS_SVH
`define RADAR_RANGE_GATE_TRACKER_UNIT_MACROS_SVH

// implication in the same cycle, off during reset
`define RRGT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, off during reset
`define RRGT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication into the next cycle, always on
`define RRGT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rrgt_pkg.sv =====
// shared constants and types for the range gate tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrgt_pkg;

   localparam int WIN_LEN_W  = 11;
   localparam int GATE_W     = 24;
   localparam int RANGE_Q8_W = 16;
   localparam int RANGE_W    = 33;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_GATE  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_Q8   = CSR_IDX_W'(2);

   // reset values
   localparam logic [WIN_LEN_W-1:0]     WIN_LEN_RST   = WIN_LEN_W'(100);
   localparam logic signed [GATE_W-1:0] INIT_GATE_RST = GATE_W'(100);
   localparam logic [RANGE_Q8_W-1:0]    RANGE_Q8_RST  = RANGE_Q8_W'(3840);

   localparam int GATE_MAX = 8388607;
   localparam int GATE_MIN = -8388608;

   typedef struct packed {
      logic [WIN_LEN_W-1:0]     window_len;
      logic signed [GATE_W-1:0] init_gate;
      logic [RANGE_Q8_W-1:0]    range_q8;
      logic                     gate_load;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/rrgt_ifs.sv =====
// request, response and register write channels of the range gate tracker
// depends on rrgt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rrgt_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_i;
   logic signed [SAMPLE_BITS-1:0] sample_q;
   logic                          track_on;

   modport source (output valid, sample_i, sample_q, track_on, input ready);
   modport sink   (input valid, sample_i, sample_q, track_on, output ready);
endinterface

interface rrgt_rsp_if #(parameter int SAMPLE_BITS = 16, parameter int IDX_W = 10);
   import rrgt_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_i;
   logic signed [SAMPLE_BITS-1:0] out_q;
   logic                          pulse_done;
   logic signed [RANGE_W-1:0]     range_m;
   logic signed [GATE_W-1:0]      gate_start;
   logic [IDX_W-1:0]              peak_index;

   modport source (output valid, out_i, out_q, pulse_done, range_m, gate_start,
                   peak_index, input ready);
   modport sink   (input valid, out_i, out_q, pulse_done, range_m, gate_start,
                   peak_index, output ready);
endinterface

interface rrgt_csr_if;
   import rrgt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/radar_range_gate_tracker_unit.sv =====
// top level of the range gate tracker
// depends on rrgt_pkg, rrgt_ifs, rrgt_csr_regs, rrgt_input_stage, rrgt_track_core
`timescale 1ns / 1ps
`default_nettype none

// Range gate tracker: takes one complex sample per request, grouped into
// pulses of window_len samples, and returns one response per request. The
// block accepts a new request every cycle while responses are taken; each
// request passes through the input register (squared magnitude) and then
// the response register (peak compare, range multiply, gate update) before
// its response is offered.
// Backpressure on the response side stalls the input side through a single
// input register, so full rate is kept while the response is taken every
// cycle. No clearing pass is needed after reset. Registers must be written
// only while no request is in flight; the block itself does not enforce this.
module radar_range_gate_tracker_unit #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rrgt_req_if.sink   req_bus,
   rrgt_rsp_if.source rsp_bus,
   rrgt_csr_if.sink   csr_bus
);
   import rrgt_pkg::*;

   cfg_type                       cfg;
   logic                          take;
   logic                          s1_valid;
   logic signed [SAMPLE_BITS-1:0] s1_i, s1_q;
   logic                          s1_track;
   logic [2*SAMPLE_BITS:0]        s1_power;

   rrgt_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   rrgt_input_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_in (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .take     (take),
      .s1_valid (s1_valid),
      .s1_i     (s1_i),
      .s1_q     (s1_q),
      .s1_track (s1_track),
      .s1_power (s1_power)
   );

   rrgt_track_core #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_i     (s1_i),
      .s1_q     (s1_q),
      .s1_track (s1_track),
      .s1_power (s1_power),
      .take     (take),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== sv/rrgt_csr_regs.sv =====
// configuration registers of the range gate tracker
// depends on rrgt_pkg and rrgt_csr_if
`timescale 1ns / 1ps
`default_nettype none

module rrgt_csr_regs (
   input  wire logic       clock,
   input  wire logic       reset,
   rrgt_csr_if.sink        csr,
   output rrgt_pkg::cfg_type cfg
);
   import rrgt_pkg::*;

   logic [WIN_LEN_W-1:0]     window_len_ff;
   logic signed [GATE_W-1:0] init_gate_ff;
   logic [RANGE_Q8_W-1:0]    range_q8_ff;
   logic                     gate_load_ff;
   logic                     wr_en;

   assign csr.ready = 1'b1;
   assign wr_en     = csr.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WIN_LEN_RST;
         init_gate_ff  <= INIT_GATE_RST;
         range_q8_ff   <= RANGE_Q8_RST;
         gate_load_ff  <= 1'b0;
      end else begin
         gate_load_ff <= 1'b0;
         if (wr_en) begin
            unique case (csr.index)
               CSR_WINDOW_LEN: window_len_ff <= csr.data[WIN_LEN_W-1:0];
               CSR_INIT_GATE: begin
                  init_gate_ff <= csr.data[GATE_W-1:0];
                  gate_load_ff <= 1'b1;
               end
               CSR_RANGE_Q8:  range_q8_ff <= csr.data[RANGE_Q8_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.window_len = window_len_ff;
   assign cfg.init_gate  = init_gate_ff;
   assign cfg.range_q8   = range_q8_ff;
   assign cfg.gate_load  = gate_load_ff;

endmodule

`default_nettype wire

// ===== sv/rrgt_input_stage.sv =====
// input register: captures one sample and its squared magnitude
// depends on rrgt_req_if
`timescale 1ns / 1ps
`default_nettype none

module rrgt_input_stage #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   rrgt_req_if.sink                     req,
   input  wire logic                    take,
   output logic                         s1_valid,
   output logic signed [SAMPLE_BITS-1:0] s1_i,
   output logic signed [SAMPLE_BITS-1:0] s1_q,
   output logic                         s1_track,
   output logic [2*SAMPLE_BITS:0]       s1_power
);
   localparam int PW_W = 2 * SAMPLE_BITS + 1;

   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] i_ff, q_ff;
   logic                          track_ff;
   logic [PW_W-1:0]               power_ff, power_in;
   logic signed [2*SAMPLE_BITS-1:0] sq_i, sq_q;
   logic                          load;

   assign sq_i     = req.sample_i * req.sample_i;
   assign sq_q     = req.sample_q * req.sample_q;
   assign power_in = PW_W'($unsigned(sq_i)) + PW_W'($unsigned(sq_q));

   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         i_ff     <= req.sample_i;
         q_ff     <= req.sample_q;
         track_ff <= req.track_on;
         power_ff <= power_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_i     = i_ff;
   assign s1_q     = q_ff;
   assign s1_track = track_ff;
   assign s1_power = power_ff;

endmodule

`default_nettype wire

// ===== sv/rrgt_track_core.sv =====
// peak search, range and gate update, and the response register
// depends on rrgt_pkg and rrgt_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module rrgt_track_core #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rrgt_pkg::cfg_type            cfg,
   input  wire logic                         s1_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] s1_i,
   input  wire logic signed [SAMPLE_BITS-1:0] s1_q,
   input  wire logic                         s1_track,
   input  wire logic [2*SAMPLE_BITS:0]       s1_power,
   output logic                              take,
   rrgt_rsp_if.source                        rsp
);
   import rrgt_pkg::*;

   localparam int IDX_W  = $clog2(MAX_WINDOW);
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int PW_W   = 2 * SAMPLE_BITS + 1;
   localparam int SUM_W  = ((IDX_W > GATE_W) ? IDX_W : GATE_W) + 2;
   localparam int G_W    = SUM_W + 1;
   localparam int PROD_W = SUM_W + RANGE_Q8_W + 1;
   localparam logic signed [G_W-1:0] G_HI = G_W'(GATE_MAX);
   localparam logic signed [G_W-1:0] G_LO = G_W'(GATE_MIN);

   // pulse state
   logic [IDX_W-1:0]         count_ff;
   logic                     tracking_ff;
   logic [PW_W-1:0]          best_power_ff;
   logic [IDX_W-1:0]         best_index_ff;
   logic signed [GATE_W-1:0] gate_ff;

   // response register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_i_ff, out_q_ff;
   logic                          done_ff;
   logic signed [RANGE_W-1:0]     range_ff;
   logic signed [GATE_W-1:0]      gate_out_ff;
   logic [IDX_W-1:0]              peak_ff;

   logic                     first;
   logic                     trk;
   logic [PW_W-1:0]          base_pw;
   logic [IDX_W-1:0]         base_idx;
   logic                     beat;
   logic [IDX_W-1:0]         new_idx;
   logic [LEN_W-1:0]         eff_len;
   logic                     last;
   logic signed [SUM_W-1:0]  sum_base, sum_cur;
   logic signed [PROD_W-1:0] rq_ext;
   logic signed [PROD_W-1:0] prod_base, prod_cur, prod_sel;
   logic signed [G_W-1:0]    g_raw;
   logic signed [GATE_W-1:0] g_sat;

   assign take = s1_valid && (!rsp_valid_ff || rsp.ready);

   // effective window length
   always_comb begin
      if (cfg.window_len == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(cfg.window_len) > 32'(MAX_WINDOW)) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = LEN_W'(cfg.window_len);
      end
   end

   assign last     = (32'(count_ff) + 32'd1) >= 32'(eff_len);
   assign first    = (count_ff == '0);
   assign trk      = first ? s1_track : tracking_ff;
   assign base_pw  = first ? '0 : best_power_ff;
   assign base_idx = first ? '0 : best_index_ff;
   assign beat     = trk && (s1_power > base_pw);
   assign new_idx  = beat ? count_ff : base_idx;

   // both candidate products, picked once the compare settles
   assign sum_base  = SUM_W'(gate_ff) + SUM_W'($signed({1'b0, base_idx}));
   assign sum_cur   = SUM_W'(gate_ff) + SUM_W'($signed({1'b0, count_ff}));
   assign rq_ext    = PROD_W'($signed({1'b0, cfg.range_q8}));
   assign prod_base = PROD_W'(sum_base) * rq_ext;
   assign prod_cur  = PROD_W'(sum_cur) * rq_ext;
   assign prod_sel  = beat ? prod_cur : prod_base;

   assign g_raw = G_W'(gate_ff) + G_W'($signed({1'b0, new_idx}))
                - G_W'($signed({1'b0, eff_len >> 1}));

   always_comb begin
      priority if (g_raw > G_HI) begin
         g_sat = GATE_W'(G_HI);
      end else if (g_raw < G_LO) begin
         g_sat = GATE_W'(G_LO);
      end else begin
         g_sat = g_raw[GATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         tracking_ff   <= 1'b0;
         best_power_ff <= '0;
         best_index_ff <= '0;
         gate_ff       <= INIT_GATE_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.gate_load) begin
            gate_ff <= cfg.init_gate;
         end else if (take && last && trk) begin
            gate_ff <= g_sat;
         end
         if (take) begin
            tracking_ff   <= trk;
            best_power_ff <= beat ? s1_power : base_pw;
            best_index_ff <= new_idx;
            count_ff      <= last ? '0 : count_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_i_ff    <= trk ? s1_i : '0;
         out_q_ff    <= trk ? s1_q : '0;
         done_ff     <= last;
         range_ff    <= (last && trk) ? prod_sel[RANGE_W+7:8] : '0;
         gate_out_ff <= last ? (trk ? g_sat : cfg.init_gate) : '0;
         peak_ff     <= (last && trk) ? new_idx : '0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_i      = out_i_ff;
   assign rsp.out_q      = out_q_ff;
   assign rsp.pulse_done = done_ff;
   assign rsp.range_m    = range_ff;
   assign rsp.gate_start = gate_out_ff;
   assign rsp.peak_index = peak_ff;

endmodule

`default_nettype wire

// ===== sv/rrgt_checker.sv =====
// port level checks for the range gate tracker, bound to the top level
// depends on rrgt_pkg and radar_range_gate_tracker_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "radar_range_gate_tracker_unit_macros.svh"

module rrgt_checker #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [SAMPLE_BITS-1:0]                out_i,
   input wire logic [SAMPLE_BITS-1:0]                out_q,
   input wire logic                                  pulse_done,
   input wire logic [rrgt_pkg::RANGE_W-1:0]          range_m,
   input wire logic [rrgt_pkg::GATE_W-1:0]           gate_start,
   input wire logic [$clog2(MAX_WINDOW)-1:0]         peak_index
);
   import rrgt_pkg::*;

   `RRGT_ASSERT_NXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid,
      "response valid after reset")

   `RRGT_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(out_i) && $stable(out_q) && $stable(pulse_done)
         && $stable(range_m) && $stable(gate_start) && $stable(peak_index),
      "stalled response changed")

   `RRGT_ASSERT_IMP(a_mid_pulse_zero, clock, reset, rsp_valid && !pulse_done,
      range_m == '0 && gate_start == '0 && peak_index == '0,
      "pulse fields set before the last sample")

endmodule

bind radar_range_gate_tracker_unit rrgt_checker #(
   .MAX_WINDOW  (MAX_WINDOW),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_rrgt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_i      (rsp_bus.out_i),
   .out_q      (rsp_bus.out_q),
   .pulse_done (rsp_bus.pulse_done),
   .range_m    (rsp_bus.range_m),
   .gate_start (rsp_bus.gate_start),
   .peak_index (rsp_bus.peak_index)
);

`default_nettype wire
